/* sv/move_toward_target_step_macros.svh */
// Assertion macros shared by the move-toward-target block.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef MOVE_TOWARD_TARGET_STEP_MACROS_SVH
`define MOVE_TOWARD_TARGET_STEP_MACROS_SVH

// Same-cycle implication, held off during reset
`define MTT_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset
`define MTT_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/mtt_pkg.sv */
// Shared types and constants for the move-toward-target block.
// No dependencies.
package mtt_pkg;

  localparam int CW    = 32;        // coordinate width
  localparam int FRAC  = 16;        // fraction bits
  localparam int RGW   = 31;        // width of the Q15.16 registers
  localparam int AW    = CW + 1;    // magnitude of a coordinate difference, distance
  localparam int NW    = 2 * AW;    // squared magnitudes, dividends
  localparam int PW    = 96;        // widest product held by the shared unit
  localparam int RW    = AW + 3;    // remainder width for divide and root
  localparam int UW    = FRAC + 1;  // unit vector component
  localparam int TW    = 64;        // scaled speed quotient
  localparam int CNT_W = 7;

  // iteration counts of the shared unit
  localparam logic [CNT_W-1:0] CNT_MUL  = CNT_W'(AW);
  localparam logic [CNT_W-1:0] CNT_DIV  = CNT_W'(NW);
  localparam logic [CNT_W-1:0] CNT_ROOT = CNT_W'(AW);
  localparam logic [CNT_W-1:0] CNT_TIM  = CNT_W'(RGW);
  localparam logic [CNT_W-1:0] CNT_UNIT = CNT_W'(UW);

  // configuration register indexes
  localparam logic [2:0] CFG_MODE  = 3'd0;
  localparam logic [2:0] CFG_SPEED = 3'd1;
  localparam logic [2:0] CFG_STOP  = 3'd2;
  localparam logic [2:0] CFG_SCALE = 3'd3;
  localparam logic [2:0] CFG_TIME  = 3'd4;

  // movement modes
  localparam logic [1:0] MODE_CONST  = 2'd0;
  localparam logic [1:0] MODE_STOP   = 2'd1;
  localparam logic [1:0] MODE_SMOOTH = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } alu_op_e;

  typedef struct packed {
    logic             start;
    alu_op_e          op;
    logic [CNT_W-1:0] count;
  } alu_req_t;

endpackage

/* sv/mtt_alu.sv */
// Shared iterative unit: shift-add multiply, restoring divide and square root.
// Depends on mtt_pkg and the macro header.
`include "move_toward_target_step_macros.svh"

module mtt_alu (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mtt_pkg::alu_req_t         req_i,
  input  logic [mtt_pkg::NW-1:0]    a_i,
  input  logic [mtt_pkg::AW-1:0]    b_i,
  output logic                      done_o,
  output logic [mtt_pkg::PW-1:0]    res_o
);
  import mtt_pkg::*;

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  alu_op_e          op_q;
  logic [PW-1:0]    acc_q, acc_d;
  logic [PW-1:0]    a_q, a_d;
  logic [NW-1:0]    q_q, q_d;
  logic [AW-1:0]    d_q;

  logic [RW-1:0]    div_rem, root_rem;
  logic [PW-1:0]    x, y;
  logic             sub;
  logic [PW:0]      sum;
  logic             ge;

  // operand selection for the single adder
  always_comb begin
    div_rem  = {acc_q[RW-2:0], a_q[NW-1]};
    root_rem = {acc_q[RW-3:0], a_q[NW-1 -: 2]};
    case (op_q)
      OP_MUL: begin
        x   = acc_q;
        y   = q_q[0] ? a_q : '0;
        sub = 1'b0;
      end
      OP_DIV: begin
        x   = {{(PW-RW){1'b0}}, div_rem};
        y   = {{(PW-AW){1'b0}}, d_q};
        sub = 1'b1;
      end
      OP_SQRT: begin
        x   = {{(PW-RW){1'b0}}, root_rem};
        y   = {{(PW-AW-2){1'b0}}, q_q[AW-1:0], 2'b01};
        sub = 1'b1;
      end
      default: begin
        x   = acc_q;
        y   = '0;
        sub = 1'b0;
      end
    endcase
    sum = {1'b0, x} + (sub ? ~{1'b0, y} : {1'b0, y}) + {{PW{1'b0}}, sub};
    ge  = ~sum[PW];
  end

  // one step of the selected operation
  always_comb begin
    case (op_q)
      OP_MUL: begin
        acc_d = sum[PW-1:0];
        a_d   = a_q << 1;
        q_d   = q_q >> 1;
      end
      OP_DIV: begin
        acc_d = ge ? sum[PW-1:0] : x;
        a_d   = a_q << 1;
        q_d   = {q_q[NW-2:0], ge};
      end
      OP_SQRT: begin
        acc_d = ge ? sum[PW-1:0] : x;
        a_d   = a_q << 2;
        q_d   = {q_q[NW-2:0], ge};
      end
      default: begin
        acc_d = acc_q;
        a_d   = a_q;
        q_d   = q_q;
      end
    endcase
  end

  // control: iteration counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OP_MUL;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.count;
        op_q   <= req_i.op;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= '0;
      a_q   <= {{(PW-NW){1'b0}}, a_i};
      q_q   <= (req_i.op == OP_MUL) ? {{(NW-AW){1'b0}}, b_i} : '0;
      d_q   <= b_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      a_q   <= a_d;
      q_q   <= q_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = (op_q == OP_MUL) ? acc_q : {{(PW-NW){1'b0}}, q_q};

  `MTT_AST_IMP(a_alu_start_idle, req_i.start, !busy_q, "start while unit busy")
  `MTT_AST_IMP(a_alu_cnt_live, busy_q, cnt_q != '0, "busy with empty count")
  `MTT_AST_NXT(a_alu_done_one, done_q, !done_q, "done held over two cycles")

endmodule

/* sv/move_toward_target_step.sv */
// Move-toward-target block: position registers, sequencer and output register.
// Depends on mtt_pkg, mtt_alu and the macro header.
//
// Usage: an item (set_position_i, target_x_i, target_y_i) is taken when
// in_valid_i is high and in_stall_o low; one result (new_x_o, new_y_o,
// moved_o) follows per item on the out channel, held while out_stall_i is high.
// Configuration is to be written through cfg_we_i / cfg_idx_i / cfg_wdata_i
// while idle; the block does not enforce this. A step item runs on one shared
// multiply / divide / root unit, one bit (two radicand bits for the root) a
// cycle: two squares and a root, then divides and multiplies that depend on the
// mode; within stop distance or in mode 3 nothing follows the root. The next
// item is taken in the cycle after its predecessor's result enters the output
// register, so a result may still wait there while a new item is worked on; a
// stalled receiver holds the block only once a second result is ready.
// Reset clears the position to zero, loads the register defaults and empties
// the output register.
`include "move_toward_target_step_macros.svh"

module move_toward_target_step (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [mtt_pkg::RGW-1:0]       cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          set_position_i,
  input  logic signed [mtt_pkg::CW-1:0] target_x_i,
  input  logic signed [mtt_pkg::CW-1:0] target_y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [mtt_pkg::CW-1:0] new_x_o,
  output logic signed [mtt_pkg::CW-1:0] new_y_o,
  output logic                          moved_o
);
  import mtt_pkg::*;

  typedef enum logic [17:0] {
    ST_IDLE   = 18'b1 << 0,
    ST_SQX    = 18'b1 << 1,
    ST_SQY    = 18'b1 << 2,
    ST_ROOT   = 18'b1 << 3,
    ST_DECIDE = 18'b1 << 4,
    ST_M1MX   = 18'b1 << 5,
    ST_M1DX   = 18'b1 << 6,
    ST_M1MY   = 18'b1 << 7,
    ST_M1DY   = 18'b1 << 8,
    ST_UX     = 18'b1 << 9,
    ST_UY     = 18'b1 << 10,
    ST_SPD    = 18'b1 << 11,
    ST_SCL    = 18'b1 << 12,
    ST_TIM    = 18'b1 << 13,
    ST_SX     = 18'b1 << 14,
    ST_SY     = 18'b1 << 15,
    ST_APPLY  = 18'b1 << 16,
    ST_DONE   = 18'b1 << 17
  } state_e;

  state_e state_q, state_d;
  logic   launch_q, launch_d;

  // configuration
  logic [1:0]     mode_q;
  logic [RGW-1:0] speed_q, stop_q, scale_q, time_q;

  // item working registers
  logic signed [CW-1:0] px_q, py_q;
  logic [AW-1:0]        ax_q, ay_q, dist_q, mx_q, my_q, s_q;
  logic                 negx_q, negy_q, moved_q;
  logic [NW-1:0]        tmp_q;
  logic [TW-1:0]        t_q;
  logic [UW-1:0]        ux_q, uy_q;

  // output register
  logic                 out_valid_q;
  logic signed [CW-1:0] new_x_q, new_y_q;
  logic                 new_moved_q;

  // shared unit
  alu_req_t      req;
  logic [NW-1:0] alu_a;
  logic [AW-1:0] alu_b;
  logic          alu_done;
  logic [PW-1:0] alu_res;

  logic                 in_acc;
  logic signed [AW-1:0] dx, dy;
  logic [AW-1:0]        diff;
  logic [PW-FRAC-1:0]   p_scaled;
  logic [AW-1:0]        s_tim;
  logic signed [CW-1:0] sat_x, sat_y;

  mtt_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  // position plus signed step, clamped to the coordinate range
  function automatic logic signed [CW-1:0] sat_step(logic signed [CW-1:0] p, logic neg,
                                                    logic [AW-1:0] m);
    logic signed [CW+2:0] sum;
    logic signed [CW+2:0] mag;
    begin
      mag = $signed({2'b00, m});
      sum = neg ? ({{3{p[CW-1]}}, p} - mag) : ({{3{p[CW-1]}}, p} + mag);
      if (sum > $signed({4'b0000, {(CW-1){1'b1}}}))
        sat_step = {1'b0, {(CW-1){1'b1}}};
      else if (sum < $signed({4'b1111, {(CW-1){1'b0}}}))
        sat_step = {1'b1, {(CW-1){1'b0}}};
      else
        sat_step = sum[CW-1:0];
    end
  endfunction

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign dx = {target_x_i[CW-1], target_x_i} - {px_q[CW-1], px_q};
  assign dy = {target_y_i[CW-1], target_y_i} - {py_q[CW-1], py_q};

  assign diff     = dist_q - {{(AW-RGW){1'b0}}, stop_q};
  assign p_scaled = alu_res[PW-1:FRAC];
  assign s_tim    = (p_scaled > {{(PW-FRAC-AW){1'b0}}, dist_q}) ? dist_q : p_scaled[AW-1:0];
  assign sat_x    = sat_step(px_q, negx_q, mx_q);
  assign sat_y    = sat_step(py_q, negy_q, my_q);

  // operands for the shared unit per sequencer step
  always_comb begin
    req.start = launch_q;
    req.op    = OP_MUL;
    req.count = CNT_MUL;
    alu_a     = '0;
    alu_b     = '0;
    case (state_q)
      ST_SQX: begin
        alu_a = {{(NW-AW){1'b0}}, ax_q};
        alu_b = ax_q;
      end
      ST_SQY: begin
        alu_a = {{(NW-AW){1'b0}}, ay_q};
        alu_b = ay_q;
      end
      ST_ROOT: begin
        req.op    = OP_SQRT;
        req.count = CNT_ROOT;
        alu_a     = tmp_q;
      end
      ST_M1MX: begin
        alu_a = {{(NW-AW){1'b0}}, ax_q};
        alu_b = diff;
      end
      ST_M1MY: begin
        alu_a = {{(NW-AW){1'b0}}, ay_q};
        alu_b = diff;
      end
      ST_M1DX, ST_M1DY: begin
        req.op    = OP_DIV;
        req.count = CNT_DIV;
        alu_a     = tmp_q;
        alu_b     = dist_q;
      end
      ST_UX: begin
        req.op    = OP_DIV;
        req.count = CNT_DIV;
        alu_a     = {{(NW-AW-FRAC){1'b0}}, ax_q, {FRAC{1'b0}}};
        alu_b     = dist_q;
      end
      ST_UY: begin
        req.op    = OP_DIV;
        req.count = CNT_DIV;
        alu_a     = {{(NW-AW-FRAC){1'b0}}, ay_q, {FRAC{1'b0}}};
        alu_b     = dist_q;
      end
      ST_SPD: begin
        alu_a = {{(NW-RGW){1'b0}}, speed_q};
        alu_b = dist_q;
      end
      ST_SCL: begin
        req.op    = OP_DIV;
        req.count = CNT_DIV;
        alu_a     = {{(NW-TW){1'b0}}, t_q};
        alu_b     = {{(AW-RGW){1'b0}}, scale_q};
      end
      ST_TIM: begin
        req.count = CNT_TIM;
        alu_a     = {{(NW-TW){1'b0}}, t_q};
        alu_b     = {{(AW-RGW){1'b0}}, time_q};
      end
      ST_SX: begin
        req.count = CNT_UNIT;
        alu_a     = {{(NW-AW){1'b0}}, s_q};
        alu_b     = {{(AW-UW){1'b0}}, ux_q};
      end
      ST_SY: begin
        req.count = CNT_UNIT;
        alu_a     = {{(NW-AW){1'b0}}, s_q};
        alu_b     = {{(AW-UW){1'b0}}, uy_q};
      end
      default: begin
        req.count = CNT_MUL;
      end
    endcase
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_acc) state_d = set_position_i ? ST_DONE : ST_SQX;
      ST_SQX:    if (alu_done) state_d = ST_SQY;
      ST_SQY:    if (alu_done) state_d = ST_ROOT;
      ST_ROOT:   if (alu_done) state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (dist_q > {{(AW-RGW){1'b0}}, stop_q} && mode_q != MODE_NONE)
          state_d = (mode_q == MODE_STOP) ? ST_M1MX : ST_UX;
        else
          state_d = ST_DONE;
      end
      ST_M1MX:   if (alu_done) state_d = ST_M1DX;
      ST_M1DX:   if (alu_done) state_d = ST_M1MY;
      ST_M1MY:   if (alu_done) state_d = ST_M1DY;
      ST_M1DY:   if (alu_done) state_d = ST_APPLY;
      ST_UX:     if (alu_done) state_d = ST_UY;
      ST_UY: begin
        if (alu_done)
          state_d = (mode_q == MODE_SMOOTH && scale_q != '0) ? ST_SPD : ST_SX;
      end
      ST_SPD:    if (alu_done) state_d = ST_SCL;
      ST_SCL:    if (alu_done) state_d = ST_TIM;
      ST_TIM:    if (alu_done) state_d = ST_SX;
      ST_SX:     if (alu_done) state_d = ST_SY;
      ST_SY:     if (alu_done) state_d = ST_APPLY;
      ST_APPLY:  state_d = ST_DONE;
      ST_DONE:   if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
    launch_d = (state_d != state_q) &&
               !(state_d inside {ST_IDLE, ST_DECIDE, ST_APPLY, ST_DONE});
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      launch_q    <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= MODE_CONST;
      speed_q     <= RGW'(65536);
      stop_q      <= '0;
      scale_q     <= RGW'(65536);
      time_q      <= RGW'(65536);
      px_q        <= '0;
      py_q        <= '0;
    end else begin
      state_q  <= state_d;
      launch_q <= launch_d;
      // configuration writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MODE:  mode_q  <= cfg_wdata_i[1:0];
          CFG_SPEED: speed_q <= cfg_wdata_i;
          CFG_STOP:  stop_q  <= cfg_wdata_i;
          CFG_SCALE: scale_q <= cfg_wdata_i;
          CFG_TIME:  time_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      // position update
      if (in_acc && set_position_i) begin
        px_q <= target_x_i;
        py_q <= target_y_i;
      end else if (state_q == ST_APPLY) begin
        px_q <= sat_x;
        py_q <= sat_y;
      end
      // output register
      if (state_q == ST_DONE && (!out_valid_q || !out_stall_i))
        out_valid_q <= 1'b1;
      else if (!out_stall_i)
        out_valid_q <= 1'b0;
    end
  end

  // item datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ax_q    <= dx[AW-1] ? (~dx + 1'b1) : dx;
      ay_q    <= dy[AW-1] ? (~dy + 1'b1) : dy;
      negx_q  <= dx[AW-1];
      negy_q  <= dy[AW-1];
      moved_q <= 1'b0;
    end
    case (state_q)
      ST_SQX:   if (alu_done) tmp_q <= alu_res[NW-1:0];
      ST_SQY:   if (alu_done) tmp_q <= tmp_q + alu_res[NW-1:0];
      ST_ROOT:  if (alu_done) dist_q <= alu_res[AW-1:0];
      ST_M1MX, ST_M1MY: if (alu_done) tmp_q <= alu_res[NW-1:0];
      ST_M1DX:  if (alu_done) mx_q <= alu_res[AW-1:0];
      ST_M1DY:  if (alu_done) my_q <= alu_res[AW-1:0];
      ST_UX:    if (alu_done) ux_q <= alu_res[UW-1:0];
      ST_UY: begin
        if (alu_done) begin
          uy_q <= alu_res[UW-1:0];
          s_q  <= (mode_q == MODE_SMOOTH) ? dist_q : {{(AW-RGW){1'b0}}, speed_q};
        end
      end
      ST_SPD:   if (alu_done) t_q <= {alu_res[TW-1:FRAC], {FRAC{1'b0}}};
      ST_SCL:   if (alu_done) t_q <= alu_res[TW-1:0];
      ST_TIM:   if (alu_done) s_q <= s_tim;
      ST_SX:    if (alu_done) mx_q <= alu_res[AW+FRAC-1:FRAC];
      ST_SY:    if (alu_done) my_q <= alu_res[AW+FRAC-1:FRAC];
      ST_APPLY: moved_q <= 1'b1;
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          new_x_q     <= px_q;
          new_y_q     <= py_q;
          new_moved_q <= moved_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign new_x_o     = new_x_q;
  assign new_y_o     = new_y_q;
  assign moved_o     = new_moved_q;

  `MTT_AST_NXT(a_acc_busy, in_acc, in_stall_o, "item taken but block not busy")
  `MTT_AST_NXT(a_load_pos, in_acc && set_position_i, px_q == $past(target_x_i) && py_q == $past(target_y_i), "load did not set position")
  `MTT_AST_IMP(a_done_in_op, alu_done, !(state_q == ST_IDLE || state_q == ST_DECIDE || state_q == ST_APPLY || state_q == ST_DONE), "unit done outside an operation step")

endmodule
